// File: hdl/nwsb_pkg.sv
// Package: shared constants, types and register codes for the shell binner.
`default_nettype none
package nwsb_pkg;
   localparam int MAX_SHELLS_DEF = 64;
   localparam int COORD_BITS_DEF = 21;
   localparam int ID_BITS = 20;
   localparam int SHELL_OUT_BITS = 6;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 63;

   typedef enum logic [2:0] {
      REG_SHELL_INC = 3'd0,
      REG_ORIGIN    = 3'd1,
      REG_SIZE      = 3'd2,
      REG_STEP      = 3'd3,
      REG_INNER     = 3'd4,
      REG_OUTER     = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_DIV  = 2'd1,
      ST_LOOK = 2'd2,
      ST_OUT  = 2'd3
   } state_type;

   // hand-off from the grading unit to the table unit
   typedef struct packed {
      logic          valid;
      logic [7:0]    shell;
      logic [ID_BITS-1:0] id;
      logic          restart;
   } grade_type;
endpackage
`default_nettype wire

// File: hdl/nested_window_shell_binner_core.sv
// Top level: stream ports, configuration registers and sequencing.
// Sequence from the accepting edge to rsp_tvalid: COORD_BITS+3
// divide steps (one quotient bit each), a finish step, a table read and a compare.
// A new point is taken only after the last one has passed its compare; a word
// still waiting on rsp_tready holds the next point at its compare.
// Reset: synchronous active high; registers clear to zero, seen flags clear at once.
`default_nettype none
module nested_window_shell_binner_core #(
   parameter int MAX_SHELLS = nwsb_pkg::MAX_SHELLS_DEF,
   parameter int COORD_BITS = nwsb_pkg::COORD_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   // tdata: coord_x, coord_y, coord_z, tube_id from bit 0, zero filled
   input  wire logic [((3*COORD_BITS+nwsb_pkg::ID_BITS+7)/8)*8-1:0] req_tdata,
   input  wire logic req_tuser,    // tuser: restart
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // tdata: shell_index [5:0], tube_out [25:6], zero filled
   output logic [31:0] rsp_tdata,
   input  wire logic csr_wr_en,
   input  wire logic [nwsb_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [nwsb_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   localparam int L = COORD_BITS;
   logic [5:0] inc_ff;
   logic [nwsb_pkg::CSR_DATA_BITS-1:0] org_ff, size_ff, step_ff, inner_ff, outer_ff;
   nwsb_pkg::state_type st_ff, st_in;
   logic [L-1:0] coord [3];
   nwsb_pkg::grade_type grade;
   logic hit_valid, emit;
   logic [nwsb_pkg::SHELL_OUT_BITS-1:0] shell_out;
   logic [nwsb_pkg::ID_BITS-1:0] id_out;
   logic [31:0] out_ff;
   logic out_vld_ff, out_vld_in;
   logic slot_free, load;
   logic start;

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff <= '0; org_ff <= '0; size_ff <= '0;
         step_ff <= '0; inner_ff <= '0; outer_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            nwsb_pkg::REG_SHELL_INC: inc_ff <= csr_wdata[5:0];
            nwsb_pkg::REG_ORIGIN:    org_ff <= csr_wdata;
            nwsb_pkg::REG_SIZE:      size_ff <= csr_wdata;
            nwsb_pkg::REG_STEP:      step_ff <= csr_wdata;
            nwsb_pkg::REG_INNER:     inner_ff <= csr_wdata;
            nwsb_pkg::REG_OUTER:     outer_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ST_OUT: a new word waits for the output register to free up
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         nwsb_pkg::ST_IDLE: if (req_tvalid) st_in = nwsb_pkg::ST_DIV;
         nwsb_pkg::ST_DIV:  if (grade.valid) st_in = nwsb_pkg::ST_LOOK;
         nwsb_pkg::ST_LOOK: begin
            if (!emit || slot_free) st_in = nwsb_pkg::ST_IDLE;
            else st_in = nwsb_pkg::ST_OUT;
         end
         nwsb_pkg::ST_OUT:  if (slot_free) st_in = nwsb_pkg::ST_IDLE;
         default: st_in = nwsb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (st_ff == nwsb_pkg::ST_IDLE);
      rsp_tvalid = out_vld_ff;
      start = req_tvalid && req_tready;
      slot_free = !out_vld_ff || rsp_tready;
      load = slot_free && ((hit_valid && emit) || st_ff == nwsb_pkg::ST_OUT);
      out_vld_in = load || (out_vld_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= nwsb_pkg::ST_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         out_vld_ff <= out_vld_in;
      end
      if (load) out_ff <= {6'd0, id_out, shell_out};
   end

   assign coord[0] = req_tdata[L-1:0];
   assign coord[1] = req_tdata[2*L-1:L];
   assign coord[2] = req_tdata[3*L-1:2*L];
   assign rsp_tdata = out_ff;

   nwsb_grade #(.MAX_SHELLS(MAX_SHELLS), .COORD_BITS(COORD_BITS)) u_grade (
      .clock, .reset, .start, .coord,
      .id(req_tdata[3*L +: nwsb_pkg::ID_BITS]), .restart(req_tuser),
      .shell_inc(inc_ff), .origin(org_ff), .size(size_ff), .step(step_ff),
      .inner(inner_ff), .outer(outer_ff), .result(grade));

   nwsb_table #(.MAX_SHELLS(MAX_SHELLS)) u_table (
      .clock, .reset, .grade, .hit_valid, .emit, .shell_out, .id_out);

`ifndef SYNTH
   a_lookup_state: assert property (@(posedge clock) disable iff (reset)
      hit_valid |-> st_ff == nwsb_pkg::ST_LOOK) else $error("lookup out of step");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata)) else $error("word changed");
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("word dropped");
`endif
endmodule
`default_nettype wire

// File: hdl/nwsb_grade.sv
// Grading unit: fold, margin compare and serial divide per axis, then minimum.
`default_nettype none
module nwsb_grade #(
   parameter int MAX_SHELLS = nwsb_pkg::MAX_SHELLS_DEF,
   parameter int COORD_BITS = nwsb_pkg::COORD_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [COORD_BITS-1:0] coord [3],
   input  wire logic [nwsb_pkg::ID_BITS-1:0] id,
   input  wire logic restart,
   input  wire logic [5:0] shell_inc,
   input  wire logic [nwsb_pkg::CSR_DATA_BITS-1:0] origin,
   input  wire logic [nwsb_pkg::CSR_DATA_BITS-1:0] size,
   input  wire logic [nwsb_pkg::CSR_DATA_BITS-1:0] step,
   input  wire logic [nwsb_pkg::CSR_DATA_BITS-1:0] inner,
   input  wire logic [nwsb_pkg::CSR_DATA_BITS-1:0] outer,
   output nwsb_pkg::grade_type result
);
   localparam int L = COORD_BITS;
   localparam int W = L + 4;          // doubled signed values
   localparam int NB = L + 3;         // dividend bits
   localparam int CW = $clog2(NB + 1);
   localparam int MAXS = MAX_SHELLS - 1;

   logic busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NB-1:0] rem_ff [3], rem_in [3];
   logic [NB-1:0] quo_ff [3], quo_in [3];
   logic [L-1:0]  dvs_ff [3], dvs_in [3];
   logic [8:0]    fix_ff [3], fix_in [3];   // bit 8: shell fixed, no divide
   logic [nwsb_pkg::ID_BITS-1:0] id_ff;
   logic rst_ff;
   logic [8:0] last_ff;
   nwsb_pkg::grade_type res_ff, res_in;
   logic [8:0] min_s, ax_q;

   logic [8:0] last_c;
   always_comb begin
      last_c = {3'd0, shell_inc} + 9'd1;
      if (last_c > 9'(MAXS)) last_c = 9'(MAXS);
   end

   // setup per axis at start
   logic [W-1:0] c2 [3], mid2 [3], lay2 [3], cor2 [3];
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         mid2[a] = (W'($signed(origin[a*L +: L])) <<< 1) + W'(size[a*L +: L]);
         lay2[a] = mid2[a] - W'(outer[a*L +: L]);
         cor2[a] = mid2[a] - W'(inner[a*L +: L]);
         c2[a] = W'($signed(coord[a])) <<< 1;
         if ($signed(c2[a]) > $signed(mid2[a])) c2[a] = (mid2[a] <<< 1) - c2[a];
      end
   end

   // start setup, remainder steps of the restoring divider, then the minimum
   logic [NB:0] trial [3];
   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      res_in = res_ff;
      res_in.valid = 1'b0;
      min_s = last_ff;
      ax_q = '0;
      for (int a = 0; a < 3; a++) begin
         rem_in[a] = rem_ff[a];
         quo_in[a] = quo_ff[a];
         dvs_in[a] = dvs_ff[a];
         fix_in[a] = fix_ff[a];
         trial[a] = {rem_ff[a][NB-1:0], quo_ff[a][NB-1]} - {(NB+1-L)'(0), dvs_ff[a]};
      end
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in = '0;
         for (int a = 0; a < 3; a++) begin
            rem_in[a] = '0;
            quo_in[a] = NB'(c2[a] - lay2[a]);
            dvs_in[a] = step[a*L +: L];
            if ($signed(c2[a]) < $signed(lay2[a])) fix_in[a] = 9'h100;
            else if ($signed(c2[a]) > $signed(cor2[a]) || dvs_in[a] == '0)
               fix_in[a] = {1'b1, last_c[7:0]};
            else fix_in[a] = 9'd0;
         end
      end else if (busy_ff) begin
         if (cnt_ff == CW'(NB)) begin
            for (int a = 0; a < 3; a++) begin
               if (fix_ff[a][8]) ax_q = {1'b0, fix_ff[a][7:0]};
               else if (quo_ff[a] >= NB'(last_ff)) ax_q = last_ff;
               else ax_q = 9'(quo_ff[a]) + 9'd1;
               if (ax_q < min_s) min_s = ax_q;
            end
            busy_in = 1'b0;
            res_in.valid = 1'b1;
            res_in.shell = min_s[7:0];
            res_in.id = id_ff;
            res_in.restart = rst_ff;
         end else begin
            cnt_in = cnt_ff + CW'(1);
            for (int a = 0; a < 3; a++) begin
               if (!trial[a][NB]) begin
                  rem_in[a] = trial[a][NB-1:0];
                  quo_in[a] = {quo_ff[a][NB-2:0], 1'b1};
               end else begin
                  rem_in[a] = {rem_ff[a][NB-2:0], quo_ff[a][NB-1]};
                  quo_in[a] = {quo_ff[a][NB-2:0], 1'b0};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         res_ff.valid <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         res_ff.valid <= res_in.valid;
      end
      cnt_ff <= cnt_in;
      res_ff.shell <= res_in.shell;
      res_ff.id <= res_in.id;
      res_ff.restart <= res_in.restart;
      for (int a = 0; a < 3; a++) begin
         rem_ff[a] <= rem_in[a];
         quo_ff[a] <= quo_in[a];
         dvs_ff[a] <= dvs_in[a];
         fix_ff[a] <= fix_in[a];
      end
      if (start && !busy_ff) begin
         id_ff <= id;
         rst_ff <= restart;
         last_ff <= last_c;
      end
   end

   assign result = res_ff;

`ifndef SYNTH
   a_shell_range: assert property (@(posedge clock) disable iff (reset)
      res_ff.valid |-> res_ff.shell <= 8'(MAXS)) else $error("shell beyond table");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      res_ff.valid |-> !busy_ff) else $error("result while dividing");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("start while dividing");
`endif
endmodule
`default_nettype wire

// File: hdl/nwsb_table.sv
// Table unit: last-id memory with seen flags, read, compare and write back.
`default_nettype none
module nwsb_table #(
   parameter int MAX_SHELLS = nwsb_pkg::MAX_SHELLS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  nwsb_pkg::grade_type grade,
   output logic hit_valid,
   output logic emit,
   output logic [nwsb_pkg::SHELL_OUT_BITS-1:0] shell_out,
   output logic [nwsb_pkg::ID_BITS-1:0] id_out
);
   localparam int SW = (MAX_SHELLS > 1) ? $clog2(MAX_SHELLS) : 1;
   logic [nwsb_pkg::ID_BITS-1:0] mem [MAX_SHELLS];
   logic [MAX_SHELLS-1:0] seen_ff, seen_in;
   logic [nwsb_pkg::ID_BITS-1:0] rd_ff;
   logic look_ff;
   logic [SW-1:0] addr_ff;
   logic [nwsb_pkg::ID_BITS-1:0] id_ff;
   logic seen_bit_ff;
   logic [SW-1:0] addr;
   assign addr = grade.shell[SW-1:0];

   always_ff @(posedge clock) begin
      rd_ff <= mem[addr];
      if (look_ff && emit) mem[addr_ff] <= id_ff;
   end

   always_comb begin
      seen_in = seen_ff;
      if (grade.valid && grade.restart) seen_in = '0;
      if (look_ff && emit) seen_in[addr_ff] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         look_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         look_ff <= grade.valid;
      end
      if (grade.valid) begin
         addr_ff <= addr;
         id_ff <= grade.id;
         seen_bit_ff <= grade.restart ? 1'b0 : seen_ff[addr];
      end
   end

   assign hit_valid = look_ff;
   assign emit = !(seen_bit_ff && rd_ff == id_ff);
   assign shell_out = nwsb_pkg::SHELL_OUT_BITS'({{8{1'b0}}, addr_ff});
   assign id_out = id_ff;

`ifndef SYNTH
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      look_ff |-> !grade.valid) else $error("lookup overlap");
   a_seen_set: assert property (@(posedge clock) disable iff (reset)
      (look_ff && emit) |=> seen_ff[$past(addr_ff)]) else $error("seen not set");
   a_look_once: assert property (@(posedge clock) disable iff (reset)
      look_ff |=> !look_ff) else $error("lookup repeated");
`endif
endmodule
`default_nettype wire

// File: tb/tb_nested_window_shell_binner_core.sv
// Testbench for the nested-window shell binner: directed table, random phases, self-checking.
`timescale 1ns / 100ps
`default_nettype none
module tb_nested_window_shell_binner_core;

   localparam int CB = nwsb_pkg::COORD_BITS_DEF;
   localparam int IDB = nwsb_pkg::ID_BITS;
   localparam int LAST_CAP = nwsb_pkg::MAX_SHELLS_DEF - 1;
   localparam int IDLE_LIMIT = 3000;
   localparam int SETTLE = 60;     // comfortably above the block's latency from point to word
   localparam int RANDOM_ITEMS = 800;

   typedef struct {
      logic [5:0]     shell;
      logic [IDB-1:0] id;
   } bin_word_type;

   typedef struct {
      logic signed [CB-1:0] x, y, z;
      logic [IDB-1:0]       id;
      bit                   restart;
      bit                   typed;
      bit                   emit;
      logic [5:0]           shell;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [87:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [nwsb_pkg::CSR_IDX_BITS-1:0] csr_index = '0;
   logic [nwsb_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   nested_window_shell_binner_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block's registers and shell table
   logic [5:0]  cfg_incr;
   logic [62:0] cfg_origin, cfg_size, cfg_step, cfg_inner, cfg_outer;
   logic [IDB-1:0] last_id [nwsb_pkg::MAX_SHELLS_DEF];
   bit  shell_seen [nwsb_pkg::MAX_SHELLS_DEF];

   bin_word_type bins_due[$];
   int err_count = 0;
   int idle_cycles = 0;

   // directed rows carry a hand-written expectation, handed over with the word
   bit row_typed = 1'b0, row_emit = 1'b0;
   logic [5:0] row_shell = '0;

   function automatic longint lane_s(logic [62:0] r, int ax);
      logic [CB-1:0] v;
      v = r[ax*CB +: CB];
      return longint'($signed(v));
   endfunction

   function automatic longint lane_u(logic [62:0] r, int ax);
      return longint'({43'd0, r[ax*CB +: CB]});
   endfunction

   function automatic longint grade_axis(logic [CB-1:0] raw, int ax, longint last);
      longint c2, mid2, layer2, core2, dx, q;
      c2 = 2 * longint'($signed(raw));
      mid2 = 2 * lane_s(cfg_origin, ax) + lane_u(cfg_size, ax);
      layer2 = mid2 - lane_u(cfg_outer, ax);
      core2 = mid2 - lane_u(cfg_inner, ax);
      dx = lane_u(cfg_step, ax);
      if (c2 > mid2) c2 = 2 * mid2 - c2;
      if (c2 < layer2) return 0;
      if (c2 > core2) return last;
      if (dx == 0) return last;
      q = (c2 - layer2) / dx + 1;
      return (q > last) ? last : q;
   endfunction

   // returns 1 when the point adds a tube to a shell's list
   function automatic bit bin_point(logic [87:0] d, bit rst, output bin_word_type w);
      longint last, s, t;
      logic [IDB-1:0] id;
      last = longint'(cfg_incr) + 1;
      if (last > LAST_CAP) last = LAST_CAP;
      id = d[3*CB +: IDB];
      if (rst) foreach (shell_seen[i]) shell_seen[i] = 1'b0;
      s = grade_axis(d[0 +: CB], 0, last);
      t = grade_axis(d[CB +: CB], 1, last);
      if (t < s) s = t;
      t = grade_axis(d[2*CB +: CB], 2, last);
      if (t < s) s = t;
      w.shell = s[5:0];
      w.id = id;
      if (shell_seen[s] && last_id[s] == id) return 1'b0;
      shell_seen[s] = 1'b1;
      last_id[s] = id;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      bin_word_type w, got;
      bit hit;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (req_tvalid && req_tready) begin
            hit = bin_point(req_tdata, req_tuser, w);
            if (row_typed) begin
               hit = row_emit;
               w.shell = row_shell;
            end
            if (hit) bins_due = {bins_due, w};
         end
         if (rsp_tvalid && rsp_tready) begin
            got.shell = rsp_tdata[5:0];
            got.id = rsp_tdata[25:6];
            if (bins_due.size() == 0) begin
               $display("%0t: unexpected word shell=%0d id=%h", $time, got.shell, got.id);
               err_count++;
            end else begin
               w = bins_due.pop_front();
               if (got.shell !== w.shell)
                  begin
                     $display("%0t: shell_index expected %0d got %0d", $time, w.shell, got.shell);
                     err_count++;
                  end
               if (got.id !== w.id) begin
                  $display("%0t: tube_out expected %h got %h", $time, w.id, got.id);
                  err_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: stall pattern switches between always ready, random and rarely ready
   int stall_mode = 0, stall_cnt = 0;
   always @(posedge clock) begin
      if (stall_cnt == 63) stall_mode <= $urandom_range(0, 2);
      stall_cnt <= (stall_cnt + 1) % 64;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic write_reg(nwsb_pkg::reg_index_type idx, logic [62:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         nwsb_pkg::REG_SHELL_INC: cfg_incr = val[5:0];
         nwsb_pkg::REG_ORIGIN:    cfg_origin = val;
         nwsb_pkg::REG_SIZE:      cfg_size = val;
         nwsb_pkg::REG_STEP:      cfg_step = val;
         nwsb_pkg::REG_INNER:     cfg_inner = val;
         nwsb_pkg::REG_OUTER:     cfg_outer = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_point(logic [CB-1:0] x, y, z, logic [IDB-1:0] id, bit rst);
      req_tdata <= {5'd0, id, z, y, x};
      req_tuser <= rst;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic pause(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // wait for all words, then let any word-less point finish inside the block
   task automatic drain();
      req_tvalid <= 1'b0;
      row_typed <= 1'b0;
      while (bins_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [62:0] pack3(logic [CB-1:0] a, b, c);
      return {c, b, a};
   endfunction

   function automatic logic [CB-1:0] rand_lane(int lo, int hi);
      return CB'($urandom_range(lo, hi));
   endfunction

   task automatic random_setup(int phase);
      logic [CB-1:0] o[3], sz[3], st[3], wi[3], wo[3];
      for (int a = 0; a < 3; a++) begin
         o[a] = ($urandom_range(0, 3) == 0) ? CB'($urandom) : rand_lane(0, 4000) - 21'd2000;
         sz[a] = ($urandom_range(0, 7) == 0) ? CB'($urandom) : rand_lane(0, 20000);
         case ($urandom_range(0, 7))
            0: st[a] = '0;
            1: st[a] = '1;
            default: st[a] = rand_lane(1, 2000);
         endcase
         wi[a] = rand_lane(0, 4000);
         wo[a] = ($urandom_range(0, 7) == 0) ? rand_lane(0, 4000)
               : wi[a] + rand_lane(0, 40000);
      end
      case (phase % 4)
         0: write_reg(nwsb_pkg::REG_SHELL_INC, 63'd0);
         1: write_reg(nwsb_pkg::REG_SHELL_INC, 63'd62);
         2: write_reg(nwsb_pkg::REG_SHELL_INC, 63'd63);
         default: write_reg(nwsb_pkg::REG_SHELL_INC, 63'($urandom_range(1, 61)));
      endcase
      write_reg(nwsb_pkg::REG_ORIGIN, pack3(o[0], o[1], o[2]));
      write_reg(nwsb_pkg::REG_SIZE, pack3(sz[0], sz[1], sz[2]));
      write_reg(nwsb_pkg::REG_STEP, pack3(st[0], st[1], st[2]));
      write_reg(nwsb_pkg::REG_INNER, pack3(wi[0], wi[1], wi[2]));
      write_reg(nwsb_pkg::REG_OUTER, pack3(wo[0], wo[1], wo[2]));
   endtask

   function automatic logic [CB-1:0] pick_coord(int ax);
      longint ctr, span;
      if ($urandom_range(0, 4) == 0) return CB'($urandom);
      ctr = lane_s(cfg_origin, ax) + lane_u(cfg_size, ax) / 2;
      span = lane_u(cfg_outer, ax) / 2 + 64;
      if (span > 1000000) span = 1000000;
      return CB'(ctr + longint'($urandom_range(0, 2 * span)) - span);
   endfunction

   dir_row_type dir_rows [16];
   logic [IDB-1:0] id_pool[8];

   initial begin
      int burst;
      // registers at reset: every non-zero coordinate lands in shell 0, the origin in shell 1
      dir_rows = '{
         '{21'sd0, 21'sd0, 21'sd0, 20'h00005, 1'b0, 1'b1, 1'b1, 6'd1},
         '{21'sd0, 21'sd0, 21'sd0, 20'h00005, 1'b0, 1'b1, 1'b0, 6'd0},
         '{21'sd1, 21'sd0, 21'sd0, 20'h00005, 1'b0, 1'b1, 1'b1, 6'd0},
         '{21'h0FFFFF, 21'h100000, 21'sd0, 20'h00005, 1'b0, 1'b1, 1'b0, 6'd0},
         '{21'sd0, 21'sd0, 21'sd0, 20'hFFFFF, 1'b1, 1'b1, 1'b1, 6'd1},
         '{21'sd0, 21'sd0, 21'sd0, 20'hFFFFF, 1'b1, 1'b1, 1'b1, 6'd1},
         // windows centred at 1024: folding, bands, clamping, zero step on z
         '{21'sd1024, 21'sd1024, 21'sd1024, 20'h00001, 1'b0, 1'b0, 1'b0, 6'd0},
         '{21'sd1100, 21'sd948, 21'sd1024, 20'h00002, 1'b0, 1'b0, 1'b0, 6'd0},
         '{21'sd600, 21'sd1024, 21'sd1024, 20'h00003, 1'b0, 1'b0, 1'b0, 6'd0},
         '{21'sd513, 21'sd1535, 21'sd700, 20'h00004, 1'b0, 1'b0, 1'b0, 6'd0},
         '{21'sd512, 21'sd512, 21'sd512, 20'h00004, 1'b0, 1'b0, 1'b0, 6'd0},
         '{21'sd511, 21'sd1024, 21'sd1024, 20'hFFFFF, 1'b0, 1'b0, 1'b0, 6'd0},
         '{21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF, 20'h00000, 1'b0, 1'b0, 1'b0, 6'd0},
         '{21'h100000, 21'h100000, 21'h100000, 20'h00000, 1'b1, 1'b0, 1'b0, 6'd0},
         '{21'sd900, 21'sd1200, 21'sd800, 20'h55555, 1'b0, 1'b0, 1'b0, 6'd0},
         '{21'sd900, 21'sd1200, 21'sd800, 20'hAAAAA, 1'b0, 1'b0, 1'b0, 6'd0}
      };
      cfg_incr = '0;
      {cfg_origin, cfg_size, cfg_step, cfg_inner, cfg_outer} = '0;
      foreach (shell_seen[i]) shell_seen[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (i == 6) begin
            drain();
            write_reg(nwsb_pkg::REG_SHELL_INC, 63'd62);
            write_reg(nwsb_pkg::REG_ORIGIN, 63'd0);
            write_reg(nwsb_pkg::REG_SIZE, pack3(21'd2048, 21'd2048, 21'd2048));
            write_reg(nwsb_pkg::REG_STEP, pack3(21'd64, 21'd1, 21'd0));
            write_reg(nwsb_pkg::REG_INNER, pack3(21'd256, 21'd256, 21'd256));
            write_reg(nwsb_pkg::REG_OUTER, pack3(21'd1024, 21'd1024, 21'd1024));
         end
         row_typed <= dir_rows[i].typed;
         row_emit <= dir_rows[i].emit;
         row_shell <= dir_rows[i].shell;
         send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].id,
                    dir_rows[i].restart);
         if (i % 3 == 2) pause($urandom_range(1, 4));
      end

      for (int phase = 0; phase < 8; phase++) begin
         drain();
         random_setup(phase);
         foreach (id_pool[k]) id_pool[k] = IDB'($urandom);
         for (int n = 0; n < RANDOM_ITEMS / 8; ) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && n < RANDOM_ITEMS / 8; b++, n++)
               send_point(pick_coord(0), pick_coord(1), pick_coord(2),
                          ($urandom_range(0, 1) != 0) ? id_pool[$urandom_range(0, 7)]
                                                     : IDB'($urandom),
                          $urandom_range(0, 15) == 0);
            if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 40));
         end
      end

      drain();
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

// File: nested_window_shell_binner_core.f
hdl/nwsb_pkg.sv
hdl/nwsb_grade.sv
hdl/nwsb_table.sv
hdl/nested_window_shell_binner_core.sv
tb/tb_nested_window_shell_binner_core.sv
